FILE: sv/json_string_escaper_defines.svh
// Assertion macros for the JSON string escaper.
// Used by the top level only; relies on clk_i and rst_ni in the including scope.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/jse_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies.
`default_nettype none

package jse_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CharQuote     = 8'h22;
  localparam logic [ByteW-1:0] CharBackslash = 8'h5C;
  localparam logic [ByteW-1:0] CharBsp       = 8'h08;
  localparam logic [ByteW-1:0] CharFf        = 8'h0C;
  localparam logic [ByteW-1:0] CharLf        = 8'h0A;
  localparam logic [ByteW-1:0] CharCr        = 8'h0D;
  localparam logic [ByteW-1:0] CharTab       = 8'h09;
  localparam logic [ByteW-1:0] CtrlLimit     = 8'h20;

  localparam logic [ByteW-1:0] AscZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] AscLowA  = 8'h61;  // 'a'
  localparam logic [ByteW-1:0] AscLowB  = 8'h62;  // 'b'
  localparam logic [ByteW-1:0] AscLowF  = 8'h66;  // 'f'
  localparam logic [ByteW-1:0] AscLowN  = 8'h6E;  // 'n'
  localparam logic [ByteW-1:0] AscLowR  = 8'h72;  // 'r'
  localparam logic [ByteW-1:0] AscLowT  = 8'h74;  // 't'
  localparam logic [ByteW-1:0] AscLowU  = 8'h75;  // 'u'

  // Index of a byte within one escape run; six bytes at most.
  localparam int unsigned IdxW = 3;
  localparam logic [IdxW-1:0] LenPass    = 3'd1;
  localparam logic [IdxW-1:0] LenShort   = 3'd2;
  localparam logic [IdxW-1:0] LenUnicode = 3'd6;

  typedef enum logic [1:0] {
    RUN_PASS,
    RUN_SHORT,
    RUN_UNICODE
  } run_kind_e;

  // One classified input byte waiting for the emitter.
  typedef struct packed {
    run_kind_e        kind;
    logic [ByteW-1:0] code;  // pass byte, escape letter, or raw control byte
    logic             eos;
  } run_entry_t;

  function automatic logic [ByteW-1:0] hex_lower(input logic [3:0] nib);
    logic [ByteW-1:0] r;
    if (nib < 4'd10) begin
      r = AscZero + {4'h0, nib};
    end else begin
      r = AscLowA + {4'h0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/jse_if.sv
// Valid/ready channel interfaces for the escaper's input and output streams.
// Depends on jse_pkg for the byte width.
`default_nettype none

interface jse_in_if import jse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] char_byte;
  logic             end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface jse_out_if import jse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_last,
                output ready);
endinterface

`default_nettype wire

FILE: sv/jse_front.sv
// Front end: accepts string bytes and classifies each into an escape run.
// Depends on jse_pkg.
`default_nettype none

module jse_front import jse_pkg::*; (
  input  wire logic [ByteW-1:0] char_byte_i,
  input  wire logic             end_of_string_i,
  output run_entry_t            entry_o
);

  always_comb begin
    entry_o.kind = RUN_PASS;
    entry_o.code = char_byte_i;
    entry_o.eos  = end_of_string_i;
    unique case (char_byte_i)
      CharQuote: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = CharQuote;
      end
      CharBackslash: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = CharBackslash;
      end
      CharBsp: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = AscLowB;
      end
      CharFf: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = AscLowF;
      end
      CharLf: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = AscLowN;
      end
      CharCr: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = AscLowR;
      end
      CharTab: begin
        entry_o.kind = RUN_SHORT;
        entry_o.code = AscLowT;
      end
      default: begin
        // other control bytes keep the raw value for the hex digits
        if (char_byte_i < CtrlLimit) begin
          entry_o.kind = RUN_UNICODE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/jse_queue.sv
// Short FIFO of classified runs between the front end and the emitter.
// Depends on jse_pkg.
`default_nettype none

module jse_queue import jse_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire run_entry_t push_entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            head_valid_o,
  output run_entry_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/jse_back.sv
// Back end: expands the head run into output bytes, one per cycle while the
// output accepts them, into an output register. Depends on jse_pkg.
`default_nettype none

module jse_back import jse_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire run_entry_t       head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  run_last_o,
  output logic                  string_last_o
);

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  run_len;
  logic [ByteW-1:0] byte_sel;
  logic             is_last;
  logic             load;
  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             run_last_q;
  logic             string_last_q;

  always_comb begin
    run_len  = LenPass;
    byte_sel = head_i.code;
    unique case (head_i.kind)
      RUN_PASS: begin
        run_len  = LenPass;
        byte_sel = head_i.code;
      end
      RUN_SHORT: begin
        run_len  = LenShort;
        byte_sel = (idx_q == '0) ? CharBackslash : head_i.code;
      end
      RUN_UNICODE: begin
        run_len = LenUnicode;
        unique case (idx_q)
          3'd0:    byte_sel = CharBackslash;
          3'd1:    byte_sel = AscLowU;
          3'd2:    byte_sel = AscZero;
          3'd3:    byte_sel = AscZero;
          3'd4:    byte_sel = hex_lower(head_i.code[7:4]);
          default: byte_sel = hex_lower(head_i.code[3:0]);
        endcase
      end
      default: begin
        run_len  = LenPass;
        byte_sel = head_i.code;
      end
    endcase
  end

  assign is_last = (idx_q == run_len - 1'b1);
  // load the output register when a run is waiting and the register is empty or being drained
  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q        <= byte_sel;
      run_last_q    <= is_last;
      string_last_q <= is_last && head_i.eos;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = string_last_q;

endmodule

`default_nettype wire

FILE: sv/json_string_escaper.sv
// JSON string escaper: one string byte per input transfer, its escaped form
// out as one to six byte transfers, each marked with run_last and, on the
// final byte of the string, string_last. Printable bytes pass at one per
// cycle while the output is ready, via the run queue and output register;
// a short escape is two bytes and a \u00XX escape six, as the emitter drives
// one byte per cycle. A QueueDepth-entry run queue lets input flow meanwhile.
`default_nettype none

`include "json_string_escaper_defines.svh"

module json_string_escaper import jse_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jse_in_if.sink     in_i,
  jse_out_if.source  out_o
);

  run_entry_t front_entry;
  run_entry_t head_entry;
  logic       q_full;
  logic       q_head_valid;
  logic       q_pop;

  assign in_i.ready = !q_full;

  jse_front u_front (
    .char_byte_i     (in_i.char_byte),
    .end_of_string_i (in_i.end_of_string),
    .entry_o         (front_entry)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_i.valid),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (head_entry)
  );

  jse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_head_valid),
    .head_i        (head_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .run_last_o    (out_o.run_last),
    .string_last_o (out_o.string_last)
  );

  // A run, once started, keeps the output busy until its last byte.
  `JSE_ASSERT_NEXT(a_run_continues, out_o.valid && out_o.ready && !out_o.run_last,
                   out_o.valid, "escape run broken before its last byte")
  // The string end only ever lands on the closing byte of a run.
  `JSE_ASSERT_NOW(a_eos_on_run_end, out_o.valid && out_o.string_last, out_o.run_last,
                  "string end flagged inside a run")
  // Input stalls only because the run queue is full.
  `JSE_ASSERT_NOW(a_stall_only_when_full, in_i.valid && !in_i.ready,
                  q_full && q_head_valid, "input stalled with room in the queue")

endmodule

`default_nettype wire

FILE: verif/json_string_escaper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for json_string_escaper: drives string bytes, predicts each escape run.
// Depends on jse_pkg, jse_in_if / jse_out_if and the json_string_escaper top level.

module json_string_escaper_tb;
  import jse_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int SettleCycles  = 20;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             string_last;
  } esc_byte_t;

  localparam logic [ByteW-1:0] HexDigits [16] = '{
    "0", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", "a", "b", "c", "d", "e", "f"
  };
  localparam logic [ByteW-1:0] ShortEsc [7] = '{
    CharQuote, CharBackslash, CharBsp, CharFf, CharLf, CharCr, CharTab
  };

  logic clk;
  logic rst_n;
  bit   src_idle_en;
  bit   sink_idle_en;
  int   err_count;
  int   chars_sent;
  int   stall_left;
  int   stuck_cycles;

  esc_byte_t escaped_q[$];

  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk = ~clk;

  // Expand one accepted byte into the run of escaped bytes it should produce.
  function automatic void predict_escape(input logic [ByteW-1:0] ch, input logic eos);
    logic [ByteW-1:0] run [6];
    int               n;
    n      = 2;
    run[0] = CharBackslash;
    case (ch)
      CharQuote, CharBackslash: run[1] = ch;
      CharBsp: run[1] = AscLowB;
      CharFf:  run[1] = AscLowF;
      CharLf:  run[1] = AscLowN;
      CharCr:  run[1] = AscLowR;
      CharTab: run[1] = AscLowT;
      default: begin
        if (ch < CtrlLimit) begin
          run[1] = AscLowU;
          run[2] = AscZero;
          run[3] = AscZero;
          run[4] = HexDigits[ch[7:4]];
          run[5] = HexDigits[ch[3:0]];
          n      = 6;
        end else begin
          run[0] = ch;
          n      = 1;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back(esc_byte_t'{out_byte: run[k], run_last: (k == n - 1),
                                      string_last: (k == n - 1) && eos});
    end
  endfunction

  function automatic logic [ByteW-1:0] rand_char(input int ctrl_pct);
    logic [ByteW-1:0] ch;
    if ($urandom_range(0, 99) < ctrl_pct) begin
      if ($urandom_range(0, 1) == 1) ch = ShortEsc[$urandom_range(0, 6)];
      else ch = ByteW'($urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 3))
        0, 1: ch = ByteW'($urandom_range(32, 126));
        2: ch = ByteW'($urandom_range(127, 255));
        default: ch = ByteW'($urandom_range(0, 255));
      endcase
    end
    return ch;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
  task automatic send_char(input logic [ByteW-1:0] ch, input logic eos);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_byte     <= ch;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_escape(ch, eos);
    chars_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed strings; a stray end flag now and then.
  task automatic send_string(input int len, input int ctrl_pct);
    for (int i = 0; i < len; i++) begin
      send_char(rand_char(ctrl_pct), (i == len - 1) || ($urandom_range(0, 19) == 0));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [ByteW-1:0] chars [22];
    chars = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h20, 8'h1F, CharQuote, CharBackslash,
              CharBsp, CharFf, CharLf, CharCr, CharTab, 8'h01, 8'h0B, 8'h1A,
              8'h41, 8'h7E, 8'h10, 8'h55, 8'hAA, 8'h5D};
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    foreach (chars[i]) send_char(chars[i], i[1:0] == 2'b11);
    // end flag on each run length
    send_char(8'h61, 1'b1);
    send_char(CharLf, 1'b1);
    send_char(8'h03, 1'b1);
  endtask

  task automatic test_mixed_strings();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    while (chars_sent < 275) send_string($urandom_range(1, 16), 25);
  endtask

  // Hold the input off until every queued run has left the block.
  task automatic test_drain_pause();
    src_idle_en = 1'b1;
    for (int r = 0; r < 3; r++) begin
      send_string($urandom_range(10, 25), 50);
      wait_drained();
    end
  endtask

  task automatic test_control_flood();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    for (int r = 0; r < 8; r++) send_string(10, 90);
  endtask

  task automatic test_streaming();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int r = 0; r < 10; r++) send_string(10, 20);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    esc_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h", $time, out_ch.out_byte);
        err_count++;
      end else begin
        want = escaped_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   out_ch.out_byte);
          err_count++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   out_ch.run_last);
          err_count++;
        end
        if (out_ch.string_last !== want.string_last) begin
          $display("%0t: string_last expected %b actual %b", $time, want.string_last,
                   out_ch.string_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WatchdogLimit) begin
      $display("json_string_escaper_tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_byte     = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_mixed_strings();
    test_drain_pause();
    test_control_flood();
    test_streaming();

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("json_string_escaper_tb: clean");
    end else begin
      $display("json_string_escaper_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/jse_pkg.sv
sv/jse_if.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper.sv
verif/json_string_escaper_tb.sv
